// ===== src/cha_pkg.sv =====
// Shared types and constants for the compacting handle allocator.
// Used by the interfaces, the handle cell and the top level.
package cha_pkg;

    localparam int ADDR_W   = 21;
    localparam int HANDLE_W = 6;
    localparam int REQ_W    = 20;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [ADDR_W-1:0] POOL_RESET = ADDR_W'(1024000);

    // Request codes
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESIZE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_HANDLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 2'd2;

    // Command broadcast to every cell
    typedef struct packed {
        logic                load;      // latch selection for a new item
        logic                alloc;     // select lowest free handle
        logic [HANDLE_W-1:0] handle;    // handle for other requests
        logic                commit;    // apply size change
        logic                delta_neg; // shift later starts down
        logic [ADDR_W-1:0]   delta;
        logic [ADDR_W-1:0]   new_size;
        logic                used_we;
        logic                used_val;
    } t_cell_cmd;

    // Read-back of the selected cell, zero when not selected
    typedef struct packed {
        logic                used;
        logic [HANDLE_W-1:0] idx;
        logic [ADDR_W-1:0]   start;
        logic [ADDR_W-1:0]   size;
    } t_cell_rd;

endpackage

// ===== src/cha_req_if.sv =====
// Request channel: valid/ready handshake with the request fields.
// Depends on cha_pkg for field widths.
interface cha_req_if;
    logic                          valid;
    logic                          ready;
    logic [cha_pkg::MODE_W-1:0]    mode;
    logic [cha_pkg::HANDLE_W-1:0]  handle;
    logic [cha_pkg::REQ_W-1:0]     new_size;

    modport source (output valid, mode, handle, new_size, input ready);
    modport sink   (input valid, mode, handle, new_size, output ready);
endinterface

// ===== src/cha_rsp_if.sv =====
// Result channel: valid/ready handshake with the result fields.
// Depends on cha_pkg for field widths.
interface cha_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cha_pkg::STATUS_W-1:0]  status;
    logic [cha_pkg::HANDLE_W-1:0]  result_handle;
    logic [cha_pkg::ADDR_W-1:0]    block_start;
    logic [cha_pkg::ADDR_W-1:0]    block_size;
    logic [cha_pkg::ADDR_W-1:0]    move_source;
    logic [cha_pkg::ADDR_W-1:0]    move_dest;
    logic [cha_pkg::ADDR_W-1:0]    move_length;

    modport source (output valid, status, result_handle, block_start, block_size,
                    move_source, move_dest, move_length, input ready);
    modport sink   (input valid, status, result_handle, block_start, block_size,
                    move_source, move_dest, move_length, output ready);
endinterface

// ===== src/compacting_handle_allocator.sv =====
// Top level of the compacting handle allocator: sequencer, pool registers
// and the row of cha_cell handle cells. Uses cha_pkg, cha_req_if, cha_rsp_if.
//
// Usage: requests (allocate, free, resize, query) arrive on i_req; each
// produces exactly one result item on o_rsp, carrying status, handle, the
// block's start and size after the request and the move (source, dest,
// length) an external DMA must perform on the bytes behind the block.
// The pool capacity register is written through i_cfg_we / i_cfg_data; the
// user must write it only while the block is idle, the block itself does
// not enforce this. It resets to 1024000 bytes.
// The sequencer walks the shared adders through cell read-back, address
// math and commit, then returns to idle to accept the next item; with one
// item in work at a time, a new item is taken only after the last commits.
// The result sits in an output register: the next item is accepted while it
// waits, and a stalled receiver holds the following item at its commit step
// until the register frees up.
// Reset (synchronous, active low) frees every handle, clears all starts and
// sizes and the pool end.
module compacting_handle_allocator #(
    parameter int NUM_HANDLES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cha_pkg::ADDR_W-1:0]    i_cfg_data,
    cha_req_if.sink                       i_req,
    cha_rsp_if.source                     o_rsp
);
    import cha_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOK   = 2'd1;
    localparam logic [1:0] S_CALC   = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0]          r_state;
    logic [ADDR_W-1:0]   r_pool_bytes;
    logic [ADDR_W-1:0]   r_pool_end;

    // Item registers
    logic [MODE_W-1:0]   r_mode;
    logic [HANDLE_W-1:0] r_h;
    logic [ADDR_W-1:0]   r_sz;

    // Read-back of the target cell
    logic                r_found;
    logic                r_used;
    logic [HANDLE_W-1:0] r_tidx;
    logic [ADDR_W-1:0]   r_start;
    logic [ADDR_W-1:0]   r_old;

    // Address math
    logic                r_active;
    logic                r_grow;
    logic                r_eq;
    logic [ADDR_W-1:0]   r_src;
    logic [ADDR_W-1:0]   r_dst;
    logic [ADDR_W-1:0]   r_up;
    logic [ADDR_W-1:0]   r_dn;

    // Output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [HANDLE_W-1:0] r_o_handle;
    logic [ADDR_W-1:0]   r_o_start;
    logic [ADDR_W-1:0]   r_o_size;
    logic [ADDR_W-1:0]   r_o_src;
    logic [ADDR_W-1:0]   r_o_dst;
    logic [ADDR_W-1:0]   r_o_len;

    t_cell_cmd           cmd;
    t_cell_rd            rd      [NUM_HANDLES];
    t_cell_rd            rd_bus;
    logic [NUM_HANDLES:0] free_chain;
    logic [NUM_HANDLES:0] sel_chain;

    logic                accept;
    logic                out_free;
    logic                do_commit;
    logic [ADDR_W:0]     grown_end;
    logic                fits;
    logic [ADDR_W-1:0]   len;
    logic [ADDR_W-1:0]   req_even;
    logic                is_alloc;

    assign accept    = i_req.valid && i_req.ready;
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign do_commit = (r_state == S_COMMIT) && out_free;
    assign is_alloc  = (r_mode == MODE_ALLOC);

    assign i_req.ready = (r_state == S_IDLE);

    // Round the request up to an even byte count
    assign req_even = ({1'b0, i_req.new_size} + ADDR_W'(1)) & ~ADDR_W'(1);

    // Growth check and move length at commit
    assign grown_end = {1'b0, r_pool_end} + {1'b0, r_up};
    assign fits      = !r_grow || (grown_end <= {1'b0, r_pool_bytes});
    assign len       = (r_eq || (r_pool_end < r_src)) ? '0 : (r_pool_end - r_src);

    // Broadcast command to the cells
    always_comb begin
        cmd           = '0;
        cmd.load      = accept;
        cmd.alloc     = (i_req.mode == MODE_ALLOC);
        cmd.handle    = i_req.handle;
        cmd.commit    = do_commit && r_active && fits;
        cmd.delta_neg = !r_grow;
        cmd.delta     = r_grow ? r_up : r_dn;
        cmd.new_size  = r_sz;
        cmd.used_we   = (r_mode == MODE_ALLOC) || (r_mode == MODE_FREE);
        cmd.used_val  = (r_mode == MODE_ALLOC);
    end

    // Row of handle cells
    assign free_chain[0] = 1'b0;
    assign sel_chain[0]  = 1'b0;

    for (genvar g = 0; g < NUM_HANDLES; g++) begin : g_cell
        cha_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_free_seen (free_chain[g]),
            .o_free_seen (free_chain[g+1]),
            .i_sel_seen  (sel_chain[g]),
            .o_sel_seen  (sel_chain[g+1]),
            .o_rd        (rd[g])
        );
    end

    // Merge the read-back of the one selected cell
    always_comb begin
        rd_bus = '0;
        for (int i = 0; i < NUM_HANDLES; i++) begin
            rd_bus = rd_bus | rd[i];
        end
    end

    // Sequencer and pool registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pool_bytes <= POOL_RESET;
            r_pool_end   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pool_bytes <= i_cfg_data;
            end
            // Load a new result or drop the one the receiver took
            if (do_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        if (r_active && fits) begin
                            r_pool_end <= r_grow ? (r_pool_end + r_up)
                                                 : (r_pool_end - r_dn);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Item datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_req.mode;
            r_h    <= i_req.handle;
            r_sz   <= (i_req.mode == MODE_FREE) ? '0 : req_even;
        end
        if (r_state == S_LOOK) begin
            r_found <= |sel_chain[NUM_HANDLES];
            r_used  <= rd_bus.used;
            r_tidx  <= rd_bus.idx;
            r_start <= rd_bus.start;
            r_old   <= rd_bus.size;
        end
        if (r_state == S_CALC) begin
            r_active <= is_alloc ? r_found
                                 : (((r_mode == MODE_FREE) || (r_mode == MODE_RESIZE)) &&
                                    (r_h != '0) && r_used);
            r_grow   <= (r_sz > r_old);
            r_eq     <= (r_sz == r_old);
            r_src    <= r_start + r_old;
            r_dst    <= r_start + r_sz;
            r_up     <= r_sz - r_old;
            r_dn     <= r_old - r_sz;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (do_commit) begin
            if (r_active && fits) begin
                r_o_status <= ST_OK;
                r_o_handle <= is_alloc ? r_tidx : r_h;
                r_o_start  <= r_start;
                r_o_size   <= r_sz;
                r_o_src    <= r_src;
                r_o_dst    <= r_dst;
                r_o_len    <= len;
            end else if (is_alloc) begin
                r_o_status <= r_found ? ST_NO_MEMORY : ST_NO_HANDLE;
                r_o_handle <= '0;
                r_o_start  <= '0;
                r_o_size   <= '0;
                r_o_src    <= '0;
                r_o_dst    <= '0;
                r_o_len    <= '0;
            end else begin
                r_o_status <= r_active ? ST_NO_MEMORY : ST_OK;
                r_o_handle <= r_h;
                r_o_start  <= r_start;
                r_o_size   <= r_old;
                r_o_src    <= '0;
                r_o_dst    <= '0;
                r_o_len    <= '0;
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.result_handle = r_o_handle;
    assign o_rsp.block_start   = r_o_start;
    assign o_rsp.block_size    = r_o_size;
    assign o_rsp.move_source   = r_o_src;
    assign o_rsp.move_dest     = r_o_dst;
    assign o_rsp.move_length   = r_o_len;

endmodule

// ===== src/cha_cell.sv =====
// One handle cell: used flag, block start and block size of one handle.
// Chains a free-seen and a select-seen flag to its neighbor; uses cha_pkg.
module cha_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cha_pkg::t_cell_cmd  i_cmd,
    input  logic                i_free_seen,
    output logic                o_free_seen,
    input  logic                i_sel_seen,
    output logic                o_sel_seen,
    output cha_pkg::t_cell_rd   o_rd
);
    import cha_pkg::*;

    logic              r_used;
    logic [ADDR_W-1:0] r_start;
    logic [ADDR_W-1:0] r_size;
    logic              r_sel;

    logic free_here;
    logic first_free;
    logic handle_hit;

    // Lowest free handle: handle 0 is never handed out
    assign free_here   = !r_used && (CELL_IDX != 0);
    assign first_free  = free_here && !i_free_seen;
    assign o_free_seen = i_free_seen || free_here;
    assign handle_hit  = (CELL_IDX < (1 << HANDLE_W)) &&
                         (i_cmd.handle == HANDLE_W'(CELL_IDX));

    // Any selected cell below this one: this block follows the target
    assign o_sel_seen = i_sel_seen || r_sel;

    // Drive the read bus only when selected
    always_comb begin
        o_rd = '0;
        if (r_sel) begin
            o_rd.used  = r_used;
            o_rd.idx   = HANDLE_W'(CELL_IDX);
            o_rd.start = r_start;
            o_rd.size  = r_size;
        end
    end

    // Select on a new item, apply the size change on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_start <= '0;
            r_size  <= '0;
            r_sel   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_sel <= i_cmd.alloc ? first_free : handle_hit;
            end
            if (i_cmd.commit) begin
                if (i_sel_seen) begin
                    r_start <= i_cmd.delta_neg ? (r_start - i_cmd.delta)
                                               : (r_start + i_cmd.delta);
                end
                if (r_sel) begin
                    r_size <= i_cmd.new_size;
                    if (i_cmd.used_we) begin
                        r_used <= i_cmd.used_val;
                    end
                end
            end
        end
    end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for compacting_handle_allocator: random and directed pool
// requests are checked against an in-bench model of the handle table.
// Depends on cha_pkg, cha_req_if, cha_rsp_if and the RTL top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cha_pkg::*;

    localparam int NUM_H       = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 200;
    localparam int unsigned ADDR_MASK = 32'h001F_FFFF;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [HANDLE_W-1:0] handle;
        logic [REQ_W-1:0]    new_size;
    } pool_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] hnd;
        logic [ADDR_W-1:0]   start;
        logic [ADDR_W-1:0]   size;
        logic [ADDR_W-1:0]   src;
        logic [ADDR_W-1:0]   dst;
        logic [ADDR_W-1:0]   len;
    } block_report_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [ADDR_W-1:0] i_cfg_data;

    cha_req_if req_bus ();
    cha_rsp_if rsp_bus ();

    compacting_handle_allocator #(
        .NUM_HANDLES(NUM_H)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus)
    );

    // Model of the handle table
    bit          handle_busy [NUM_H];
    int unsigned blk_start   [NUM_H];
    int unsigned blk_size    [NUM_H];
    int unsigned pool_end_m;
    int unsigned pool_cap;

    pool_req_t     pool_requests[$];
    block_report_t expected_reports[$];
    pool_req_t     cur_req;
    bit            req_live;
    bit            send_hold;
    bit            rx_hold;
    bit            stall_go;
    int            tx_idle_pct;
    int            rx_idle_pct;
    int            err_cnt;
    int            cycle_cnt;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Change the size of handle h to sz; refuse growth past the pool capacity
    task automatic reshape_block(input int h, input int unsigned sz, output bit ok,
                                 output block_report_t r);
        int unsigned old_sz;
        int unsigned st;
        int unsigned src;
        int unsigned dst;
        int unsigned mv_len;
        old_sz = blk_size[h];
        st     = blk_start[h];
        src    = (st + old_sz) & ADDR_MASK;
        dst    = (st + sz) & ADDR_MASK;
        r      = '0;
        ok     = 1'b0;
        if (!(sz > old_sz && longint'(pool_end_m) + (sz - old_sz) > longint'(pool_cap))) begin
            ok     = 1'b1;
            mv_len = (sz == old_sz || pool_end_m < src) ? 0 : pool_end_m - src;
            if (sz >= old_sz) begin
                pool_end_m = (pool_end_m + (sz - old_sz)) & ADDR_MASK;
                for (int i = h + 1; i < NUM_H; i++)
                    blk_start[i] = (blk_start[i] + (sz - old_sz)) & ADDR_MASK;
            end else begin
                pool_end_m = (pool_end_m - (old_sz - sz)) & ADDR_MASK;
                for (int i = h + 1; i < NUM_H; i++)
                    blk_start[i] = (blk_start[i] - (old_sz - sz)) & ADDR_MASK;
            end
            blk_size[h] = sz;
            r.status = ST_OK;
            r.hnd    = HANDLE_W'(h);
            r.start  = ADDR_W'(st);
            r.size   = ADDR_W'(sz);
            r.src    = ADDR_W'(src);
            r.dst    = ADDR_W'(dst);
            r.len    = ADDR_W'(mv_len);
        end
    endtask

    // Apply one request to the model and return the block report it yields
    task automatic serve_pool_request(input pool_req_t q, output block_report_t e);
        int unsigned sz;
        int          free_h;
        int          h;
        bit          ok;
        sz = (int'(q.new_size) + 1) & 32'hFFFF_FFFE;
        h  = q.handle;
        e  = '0;
        if (q.mode == MODE_ALLOC) begin
            free_h = 0;
            for (int i = NUM_H - 1; i >= 1; i--)
                if (!handle_busy[i]) free_h = i;
            if (free_h == 0) begin
                e.status = ST_NO_HANDLE;
            end else begin
                reshape_block(free_h, sz, ok, e);
                if (ok) handle_busy[free_h] = 1'b1;
                else e.status = ST_NO_MEMORY;
            end
        end else if (q.mode == MODE_QUERY || h == 0 || !handle_busy[h]) begin
            e.hnd   = q.handle;
            e.start = ADDR_W'(blk_start[h]);
            e.size  = ADDR_W'(blk_size[h]);
        end else if (q.mode == MODE_FREE) begin
            reshape_block(h, 0, ok, e);
            handle_busy[h] = 1'b0;
        end else begin
            reshape_block(h, sz, ok, e);
            if (!ok) begin
                e.status = ST_NO_MEMORY;
                e.hnd    = q.handle;
                e.start  = ADDR_W'(blk_start[h]);
                e.size   = ADDR_W'(blk_size[h]);
            end
        end
    endtask

    // Drive requests: hold each item until accepted, idle at random between items
    always @(negedge i_clk) begin
        if (i_rst_n && !req_live && !send_hold && pool_requests.size() > 0
            && $urandom_range(0, 99) >= tx_idle_pct) begin
            cur_req  = pool_requests.pop_front();
            req_live = 1'b1;
        end
        req_bus.valid    <= req_live;
        req_bus.mode     <= cur_req.mode;
        req_bus.handle   <= cur_req.handle;
        req_bus.new_size <= cur_req.new_size;
    end

    // Predict on acceptance
    always @(posedge i_clk) begin
        block_report_t e;
        if (i_rst_n && req_live && req_bus.valid && req_bus.ready) begin
            serve_pool_request(cur_req, e);
            expected_reports.push_back(e);
            req_live = 1'b0;
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        rsp_bus.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Long receiver stall, counted in cycles
    initial begin
        rx_hold = 1'b0;
        wait (stall_go);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (80) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        block_report_t got;
        block_report_t e;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            got.status = rsp_bus.status;
            got.hnd    = rsp_bus.result_handle;
            got.start  = rsp_bus.block_start;
            got.size   = rsp_bus.block_size;
            got.src    = rsp_bus.move_source;
            got.dst    = rsp_bus.move_dest;
            got.len    = rsp_bus.move_length;
            if (expected_reports.size() == 0) begin
                err_cnt++;
                if (err_cnt <= REPORT_MAX)
                    $display("%0t: unexpected result: expected none, got st=%0d h=%0d",
                             $time, got.status, got.hnd);
            end else begin
                e = expected_reports.pop_front();
                if (got !== e) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_MAX)
                        $display({"%0t: mismatch expected st=%0d h=%0d start=%0d size=%0d ",
                                  "src=%0d dst=%0d len=%0d, actual st=%0d h=%0d start=%0d ",
                                  "size=%0d src=%0d dst=%0d len=%0d"},
                                 $time, e.status, e.hnd, e.start, e.size, e.src, e.dst,
                                 e.len, got.status, got.hnd, got.start, got.size, got.src,
                                 got.dst, got.len);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("** compacting_handle_allocator: FAILED **");
            $finish;
        end
    end

    task automatic push_req(input logic [MODE_W-1:0] m, input int h, input int unsigned s);
        pool_req_t q;
        q.mode     = m;
        q.handle   = HANDLE_W'(h);
        q.new_size = REQ_W'(s);
        pool_requests.push_back(q);
    endtask

    // Random request: mostly low handles that tend to be in use, mixed sizes
    function automatic pool_req_t random_request();
        pool_req_t q;
        int        k;
        k = $urandom_range(0, 99);
        if (k < 35)      q.mode = MODE_ALLOC;
        else if (k < 55) q.mode = MODE_FREE;
        else if (k < 85) q.mode = MODE_RESIZE;
        else             q.mode = MODE_QUERY;
        q.handle = ($urandom_range(0, 99) < 60) ? HANDLE_W'($urandom_range(1, 16))
                                                : HANDLE_W'($urandom_range(0, 63));
        k = $urandom_range(0, 99);
        if (k < 40)      q.new_size = REQ_W'($urandom_range(0, 64));
        else if (k < 70) q.new_size = REQ_W'($urandom_range(0, 4096));
        else if (k < 85) q.new_size = REQ_W'($urandom_range(0, 65536));
        else if (k < 95) q.new_size = REQ_W'($urandom_range(0, 20'hFFFFF));
        else begin
            case ($urandom_range(0, 3))
                0: q.new_size = '0;
                1: q.new_size = REQ_W'(1);
                2: q.new_size = '1;
                default: q.new_size = 20'hFFFFE;
            endcase
        end
        return q;
    endfunction

    task automatic add_random(input int n);
        repeat (n) pool_requests.push_back(random_request());
    endtask

    // Wait until every item is accepted and answered, then let the block settle
    task automatic drain();
        wait (pool_requests.size() == 0 && !req_live && expected_reports.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_pool_cap(input int unsigned v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= ADDR_W'(v);
        pool_cap    = v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Main sequence
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = '0;
        req_bus.valid    = 1'b0;
        req_bus.mode     = MODE_QUERY;
        req_bus.handle   = '0;
        req_bus.new_size = '0;
        rsp_bus.ready    = 1'b0;
        cur_req          = '0;
        req_live         = 1'b0;
        send_hold        = 1'b0;
        stall_go         = 1'b0;
        err_cnt          = 0;
        cycle_cnt        = 0;
        tx_idle_pct      = 9;
        rx_idle_pct      = 64;
        pool_cap         = POOL_RESET;
        pool_end_m       = 0;
        for (int i = 0; i < NUM_H; i++) begin
            handle_busy[i] = 1'b0;
            blk_start[i]   = 0;
            blk_size[i]    = 0;
        end

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ignored handles, rounding, growth, last handle, refusals
        push_req(MODE_QUERY, 0, 0);
        push_req(MODE_FREE, 0, 0);
        push_req(MODE_RESIZE, 5, 100);
        push_req(MODE_ALLOC, 63, 0);
        push_req(MODE_ALLOC, 0, 1);
        push_req(MODE_ALLOC, 0, 20'hFFFFF);
        push_req(MODE_ALLOC, 0, 1000);
        push_req(MODE_RESIZE, 2, 2);
        push_req(MODE_RESIZE, 2, 101);
        push_req(MODE_RESIZE, 3, 3000);
        push_req(MODE_RESIZE, 2, 20'hFFFFF);
        push_req(MODE_QUERY, 3, 0);
        push_req(MODE_FREE, 2, 0);
        push_req(MODE_ALLOC, 0, 7);
        push_req(MODE_QUERY, 63, 20'hFFFFF);
        push_req(MODE_FREE, 63, 0);
        push_req(MODE_RESIZE, 1, 0);
        push_req(MODE_QUERY, 1, 0);
        push_req(MODE_RESIZE, 3, 0);
        push_req(MODE_ALLOC, 0, 20'hFFFFE);
        push_req(MODE_QUERY, 2, 0);
        drain();

        // Reset capacity, then 4096; sender rarely idle, receiver often idle
        add_random(300);
        drain();
        write_pool_cap(4096);
        add_random(300);
        drain();

        // Swap idling, largest and smallest capacity
        tx_idle_pct = 64;
        rx_idle_pct = 9;
        write_pool_cap(1048576);
        add_random(300);
        drain();
        write_pool_cap(0);
        add_random(150);
        drain();

        // No idling; long receiver stall, then a sender pause until all answered; then capacity 600
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_pool_cap(20000);
        add_random(400);
        stall_go = 1'b1;
        wait (pool_requests.size() < 150);
        @(posedge i_clk);
        send_hold = 1'b1;
        wait (!req_live && expected_reports.size() == 0);
        @(posedge i_clk);
        send_hold = 1'b0;
        drain();
        write_pool_cap(600);
        add_random(375);
        drain();

        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("** compacting_handle_allocator: PASSED **");
        end else begin
            $display("** compacting_handle_allocator: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/cha_pkg.sv
src/cha_req_if.sv
src/cha_rsp_if.sv
src/cha_cell.sv
src/compacting_handle_allocator.sv
dv/tb.sv
